// ===== rtl/hex_and_percent_text_codec_defines.svh =====
// ----------------------------------------------------------------------------
// hex_and_percent_text_codec_defines
// assertion macros shared by the codec checker
// ----------------------------------------------------------------------------
`ifndef HEX_AND_PERCENT_TEXT_CODEC_DEFINES_SVH
`define HEX_AND_PERCENT_TEXT_CODEC_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("codec check failed");

// next-cycle implication, disabled while in reset
`define HPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("codec check failed");

`endif

// ===== rtl/hpc_pkg.sv =====
// ----------------------------------------------------------------------------
// hpc_pkg
// types, character constants and helper functions of the text codec
// ----------------------------------------------------------------------------
package hpc_pkg;

    typedef enum logic [1:0] {
        MODE_HEX_ENC = 2'd0,
        MODE_HEX_DEC = 2'd1,
        MODE_URL_ENC = 2'd2,
        MODE_URL_DEC = 2'd3
    } t_mode;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_error;
    } t_out_item;

    // up to three characters produced by one input byte
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] chars;
        logic            last;
        logic            err;
    } t_job;

    // {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] v, input logic upper);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else if (upper) begin
            r = 8'h37 + {4'h0, v};
        end else begin
            r = 8'h57 + {4'h0, v};
        end
        return r;
    endfunction

    function automatic logic unreserved(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
               (c inside {CH_DASH, CH_UNDER, CH_DOT, CH_TILDE});
    endfunction

endpackage

// ===== rtl/hpc_front.sv =====
// ----------------------------------------------------------------------------
// hpc_front
// accepts input bytes, tracks digit state and builds a job for each byte that yields characters or an error
// ----------------------------------------------------------------------------
module hpc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_codec_mode_we,
    input  logic [1:0]       i_codec_mode,
    input  logic             i_accept,
    input  hpc_pkg::t_in_item i_item,
    output logic             o_job_we,
    output hpc_pkg::t_job    o_job
);

    hpc_pkg::t_mode r_mode;
    logic [1:0]     r_phase;
    logic [3:0]     r_hn;
    logic           r_err;

    logic [1:0]     n_phase;
    logic [3:0]     n_hn;
    logic           n_err;
    logic [4:0]     nib;
    logic [7:0]     c;
    logic [1:0]     cnt;
    logic [2:0][7:0] chars;

    assign c   = i_item.in_byte;
    assign nib = hpc_pkg::hex_nibble(c);

    always_comb begin
        n_phase = r_phase;
        n_hn    = r_hn;
        n_err   = r_err;
        cnt     = 2'd0;
        chars   = '0;
        if (!r_err) begin
            case (r_mode)
                hpc_pkg::MODE_HEX_ENC: begin
                    n_phase  = hpc_pkg::PHASE_IDLE;
                    n_hn     = 4'h0;
                    chars[0] = hpc_pkg::digit_char(c[7:4], 1'b0);
                    chars[1] = hpc_pkg::digit_char(c[3:0], 1'b0);
                    cnt      = 2'd2;
                end
                hpc_pkg::MODE_HEX_DEC: begin
                    if (!nib[4]) begin
                        n_err = 1'b1;
                    end else if (r_phase == hpc_pkg::PHASE_FIRST) begin
                        chars[0] = {r_hn, nib[3:0]};
                        cnt      = 2'd1;
                        n_phase  = hpc_pkg::PHASE_IDLE;
                        n_hn     = 4'h0;
                    end else begin
                        n_hn    = nib[3:0];
                        n_phase = hpc_pkg::PHASE_FIRST;
                    end
                end
                hpc_pkg::MODE_URL_ENC: begin
                    n_phase = hpc_pkg::PHASE_IDLE;
                    n_hn    = 4'h0;
                    if (hpc_pkg::unreserved(c)) begin
                        chars[0] = c;
                        cnt      = 2'd1;
                    end else begin
                        chars[0] = hpc_pkg::CH_PERCENT;
                        chars[1] = hpc_pkg::digit_char(c[7:4], 1'b1);
                        chars[2] = hpc_pkg::digit_char(c[3:0], 1'b1);
                        cnt      = 2'd3;
                    end
                end
                hpc_pkg::MODE_URL_DEC: begin
                    if (r_phase == hpc_pkg::PHASE_FIRST || r_phase == hpc_pkg::PHASE_SECOND) begin
                        if (!nib[4]) begin
                            n_err = 1'b1;
                        end else if (r_phase == hpc_pkg::PHASE_FIRST) begin
                            n_hn    = nib[3:0];
                            n_phase = hpc_pkg::PHASE_SECOND;
                        end else begin
                            chars[0] = {r_hn, nib[3:0]};
                            cnt      = 2'd1;
                            n_phase  = hpc_pkg::PHASE_IDLE;
                            n_hn     = 4'h0;
                        end
                    end else if (c == hpc_pkg::CH_PERCENT) begin
                        n_phase = hpc_pkg::PHASE_FIRST;
                    end else begin
                        chars[0] = c;
                        cnt      = 2'd1;
                    end
                end
                default: begin
                    cnt = 2'd0;
                end
            endcase
        end

        o_job.last = i_item.in_last;
        o_job.err  = 1'b0;
        o_job.cnt  = cnt;
        o_job.chars = chars;
        if (i_item.in_last) begin
            // pending digit pair at end of string
            if (!n_err && n_phase != hpc_pkg::PHASE_IDLE && r_mode[0]) begin
                n_err = 1'b1;
            end
            if (n_err) begin
                o_job.err   = 1'b1;
                o_job.cnt   = 2'd1;
                o_job.chars = '0;
            end
            n_phase = hpc_pkg::PHASE_IDLE;
            n_hn    = 4'h0;
            n_err   = 1'b0;
        end
    end

    assign o_job_we = i_accept && (o_job.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hpc_pkg::MODE_HEX_ENC;
            r_phase <= hpc_pkg::PHASE_IDLE;
            r_hn    <= 4'h0;
            r_err   <= 1'b0;
        end else begin
            if (i_codec_mode_we) begin
                r_mode <= hpc_pkg::t_mode'(i_codec_mode);
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_hn    <= n_hn;
                r_err   <= n_err;
            end
        end
    end

endmodule

// ===== rtl/hpc_queue.sv =====
// ----------------------------------------------------------------------------
// hpc_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module hpc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  hpc_pkg::t_job i_job,
    input  logic          i_re,
    output hpc_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hpc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_we && !o_full;
    assign rd_en   = i_re && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/hpc_back.sv =====
// ----------------------------------------------------------------------------
// hpc_back
// serializes queued jobs, one result per cycle unless the reader stalls, through an output register
// ----------------------------------------------------------------------------
module hpc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpc_pkg::t_job      i_job,
    input  logic               i_job_empty,
    output logic               o_job_re,
    input  logic               i_pop,
    output logic               o_empty,
    output hpc_pkg::t_out_item o_out_item
);

    logic [1:0]         r_idx;
    logic               r_valid;
    hpc_pkg::t_out_item r_out;

    logic [1:0]         n_idx;
    logic               n_valid;
    hpc_pkg::t_out_item n_out;
    logic               load;
    logic               final_char;

    assign load       = !r_valid || i_pop;
    assign final_char = (r_idx == i_job.cnt - 2'd1);

    always_comb begin
        n_idx    = r_idx;
        n_valid  = r_valid;
        n_out    = r_out;
        o_job_re = 1'b0;
        if (load) begin
            n_valid = !i_job_empty;
            if (!i_job_empty) begin
                n_out.out_byte  = i_job.chars[r_idx];
                n_out.out_last  = i_job.last && final_char;
                n_out.out_error = i_job.err;
                if (final_char) begin
                    o_job_re = 1'b1;
                    n_idx    = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty    = !r_valid;
    assign o_out_item = r_out;

endmodule

// ===== rtl/hex_and_percent_text_codec.sv =====
// ----------------------------------------------------------------------------
// hex_and_percent_text_codec
// byte-stream hex and url percent codec, mode chosen by codec_mode register
// ----------------------------------------------------------------------------
// input side is a queue write port: a byte transfers when push is high and
// full is low. result side is a queue read port: the oldest result sits on
// o_out_item while empty is low and transfers when pop is high.
// codec_mode must be written by i_codec_mode_we / i_codec_mode only while
// idle; the block itself does not enforce this. a byte's job is written to
// the job queue, and the back then loads its first result into the output
// register. the front takes one byte per cycle while full is low; the back
// emits one result per cycle from its output register unless the reader
// stalls. a byte yields 0 or 1 result (decode), 2 (hex encode) or 1 to 3
// (url encode); the back serializer sets the sustained byte rate.
// a stalled receiver holds the current result; the job queue (DEPTH jobs)
// keeps taking bytes until it fills, then full rises. synchronous reset
// sets hex encode and clears digit state, error flag, queue, output valid.
// ----------------------------------------------------------------------------
module hex_and_percent_text_codec #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_codec_mode_we,
    input  logic [1:0]         i_codec_mode,
    input  logic               push,
    output logic               full,
    input  hpc_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output hpc_pkg::t_out_item o_out_item
);

    logic          job_we;
    logic          job_re;
    logic          job_empty;
    hpc_pkg::t_job front_job;
    hpc_pkg::t_job head_job;

    hpc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_codec_mode_we (i_codec_mode_we),
        .i_codec_mode    (i_codec_mode),
        .i_accept        (push && !full),
        .i_item          (i_in_item),
        .o_job_we        (job_we),
        .o_job           (front_job)
    );

    hpc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (job_we),
        .i_job   (front_job),
        .i_re    (job_re),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (job_empty)
    );

    hpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_empty (job_empty),
        .o_job_re    (job_re),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/hpc_checker.sv =====
// ----------------------------------------------------------------------------
// hpc_checker
// port-level checks of the text codec, bound to the top level
// ----------------------------------------------------------------------------
`include "hex_and_percent_text_codec_defines.svh"

module hpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input hpc_pkg::t_out_item o_out_item
);

    // stalled result holds until transfer
    `HPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_item))

    // error result is a zero byte closing the string
    `HPC_ASSERT_NOW(a_err_form, i_clk, i_rst_n, !empty && o_out_item.out_error, o_out_item.out_byte == 8'h00 && o_out_item.out_last)

    // a full queue always has a result waiting (for DEPTH above one)
    `HPC_ASSERT_NOW(a_full_busy, i_clk, i_rst_n, full, !empty)

endmodule

bind hex_and_percent_text_codec hpc_checker u_checker (.*);

// ===== dv/codec_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// codec_checker
// watches the byte and result transfers of the text codec, predicts every
// result from its own copy of the mode and digit state, and compares them
// ----------------------------------------------------------------------------
module codec_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mode_we,
    input  logic [1:0]         i_mode,
    input  logic               i_push,
    input  logic               i_full,
    input  hpc_pkg::t_in_item  i_in_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  hpc_pkg::t_out_item i_out_item,
    output int                 o_mismatch_cnt,
    output int                 o_pending
);

    hpc_pkg::t_mode     cur_mode;
    logic [1:0]         dig_phase;
    logic [3:0]         hi_nib;
    logic               str_bad;
    hpc_pkg::t_out_item out_chars_q[$];
    int                 mismatches = 0;

    function automatic logic hex_value(input logic [7:0] c, output logic [3:0] v);
        v = c[3:0];
        if (c >= "0" && c <= "9") return 1'b1;
        v = c[3:0] + 4'd9;
        return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [7:0] nib_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    function automatic logic url_safe(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == hpc_pkg::CH_DASH ||
               c == hpc_pkg::CH_UNDER || c == hpc_pkg::CH_DOT ||
               c == hpc_pkg::CH_TILDE;
    endfunction

    task automatic apply_codec(input hpc_pkg::t_in_item item);
        logic [7:0]         chars [3];
        logic [7:0]         b;
        logic [3:0]         v;
        logic               ok;
        int                 n;
        hpc_pkg::t_out_item r;
        n = 0;
        v = 4'h0;
        b = item.in_byte;
        if (!str_bad) begin
            case (cur_mode)
                hpc_pkg::MODE_HEX_ENC: begin
                    dig_phase = hpc_pkg::PHASE_IDLE;
                    hi_nib    = 4'h0;
                    chars[0]  = nib_char(b[7:4], 1'b0);
                    chars[1]  = nib_char(b[3:0], 1'b0);
                    n = 2;
                end
                hpc_pkg::MODE_HEX_DEC: begin
                    ok = hex_value(b, v);
                    if (!ok) begin
                        str_bad = 1'b1;
                    end else if (dig_phase == hpc_pkg::PHASE_FIRST) begin
                        chars[0]  = {hi_nib, v};
                        n         = 1;
                        dig_phase = hpc_pkg::PHASE_IDLE;
                        hi_nib    = 4'h0;
                    end else begin
                        hi_nib    = v;
                        dig_phase = hpc_pkg::PHASE_FIRST;
                    end
                end
                hpc_pkg::MODE_URL_ENC: begin
                    dig_phase = hpc_pkg::PHASE_IDLE;
                    hi_nib    = 4'h0;
                    if (url_safe(b)) begin
                        chars[0] = b;
                        n = 1;
                    end else begin
                        chars[0] = hpc_pkg::CH_PERCENT;
                        chars[1] = nib_char(b[7:4], 1'b1);
                        chars[2] = nib_char(b[3:0], 1'b1);
                        n = 3;
                    end
                end
                hpc_pkg::MODE_URL_DEC: begin
                    if (dig_phase == hpc_pkg::PHASE_FIRST ||
                        dig_phase == hpc_pkg::PHASE_SECOND) begin
                        ok = hex_value(b, v);
                        if (!ok) begin
                            str_bad = 1'b1;
                        end else if (dig_phase == hpc_pkg::PHASE_FIRST) begin
                            hi_nib    = v;
                            dig_phase = hpc_pkg::PHASE_SECOND;
                        end else begin
                            chars[0]  = {hi_nib, v};
                            n         = 1;
                            dig_phase = hpc_pkg::PHASE_IDLE;
                            hi_nib    = 4'h0;
                        end
                    end else if (b == hpc_pkg::CH_PERCENT) begin
                        dig_phase = hpc_pkg::PHASE_FIRST;
                    end else begin
                        chars[0] = b;
                        n = 1;
                    end
                end
                default: begin
                    n = 0;
                end
            endcase
        end
        // unfinished digit pair at the end of the string
        if (item.in_last && !str_bad && dig_phase != hpc_pkg::PHASE_IDLE &&
            (cur_mode == hpc_pkg::MODE_HEX_DEC || cur_mode == hpc_pkg::MODE_URL_DEC)) begin
            str_bad = 1'b1;
        end
        if (item.in_last && str_bad) begin
            r.out_byte  = 8'h00;
            r.out_last  = 1'b1;
            r.out_error = 1'b1;
            out_chars_q.push_back(r);
        end else begin
            for (int k = 0; k < n; k++) begin
                r.out_byte  = chars[k];
                r.out_last  = item.in_last && (k == n - 1);
                r.out_error = 1'b0;
                out_chars_q.push_back(r);
            end
        end
        if (item.in_last) begin
            dig_phase = hpc_pkg::PHASE_IDLE;
            hi_nib    = 4'h0;
            str_bad   = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        hpc_pkg::t_out_item want;
        if (!i_rst_n) begin
            cur_mode  = hpc_pkg::MODE_HEX_ENC;
            dig_phase = hpc_pkg::PHASE_IDLE;
            hi_nib    = 4'h0;
            str_bad   = 1'b0;
            out_chars_q.delete();
        end else begin
            if (i_mode_we) cur_mode = hpc_pkg::t_mode'(i_mode);
            if (i_push && !i_full) apply_codec(i_in_item);
            if (i_pop && !i_empty) begin
                if (out_chars_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transfer: byte %02h last %0b err %0b",
                                 i_out_item.out_byte, i_out_item.out_last,
                                 i_out_item.out_error);
                    end
                end else begin
                    want = out_chars_q.pop_front();
                    if (want !== i_out_item) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result mismatch: expected byte %02h last %0b ",
                                      "err %0b, got byte %02h last %0b err %0b"},
                                     want.out_byte, want.out_last, want.out_error,
                                     i_out_item.out_byte, i_out_item.out_last,
                                     i_out_item.out_error);
                        end
                    end
                end
            end
        end
        o_pending      <= out_chars_q.size();
        o_mismatch_cnt <= mismatches;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives strings of bytes in all four codec modes through the text codec with
// bursty input and a stalling reader; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEM_TARGET = 480;
    localparam int DRAIN_TAIL  = 32;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               mode_we  = 1'b0;
    logic [1:0]         mode_val = 2'd0;
    logic               push     = 1'b0;
    logic               full;
    hpc_pkg::t_in_item  in_item  = '0;
    logic               empty;
    logic               pop      = 1'b0;
    hpc_pkg::t_out_item out_item;

    int mismatch_cnt;
    int pending_cnt;

    logic [7:0]     str_q[$];
    int             burst_left = 0;
    int             item_cnt   = 0;
    int             phase_idx  = 0;
    int             phase_len;
    int             phase_start;
    hpc_pkg::t_mode cur_mode;
    string          hex_digits  = "0123456789abcdefABCDEF";
    string          mixed_chars = "-_.~%+/ Zz09";

    int rx_style  = 0;
    int rx_left   = 0;
    int rx_tick   = 0;
    int rx_period = 1;

    always #10 i_clk = ~i_clk;

    hex_and_percent_text_codec u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_codec_mode_we (mode_we),
        .i_codec_mode    (mode_val),
        .push            (push),
        .full            (full),
        .i_in_item       (in_item),
        .empty           (empty),
        .pop             (pop),
        .o_out_item      (out_item)
    );

    codec_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode_we      (mode_we),
        .i_mode         (mode_val),
        .i_push         (push),
        .i_full         (full),
        .i_in_item      (in_item),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_out_item     (out_item),
        .o_mismatch_cnt (mismatch_cnt),
        .o_pending      (pending_cnt)
    );

    // reader stall pattern
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style  = $urandom_range(0, 2);
            rx_period = $urandom_range(2, 8);
            rx_left   = $urandom_range(20, 80);
            rx_tick   = 0;
        end
        rx_left--;
        rx_tick++;
        case (rx_style)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 99) < 55);
            default: pop <= (rx_tick % rx_period == 0);
        endcase
    end

    function automatic logic [7:0] rand_hex_digit();
        return hex_digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_non_hex();
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range(8'h00, 8'h2F));
            1: return 8'($urandom_range(8'h67, 8'h7A));
            default: return {1'b1, 7'($urandom)};
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic l);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        push    <= 1'b1;
        in_item <= {b, l};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left--;
        item_cnt++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++) begin
            put_byte(str_q[i], i == str_q.size() - 1);
        end
    endtask

    // wait until every expected result has been transferred
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic set_mode(input hpc_pkg::t_mode m);
        mode_we  <= 1'b1;
        mode_val <= m;
        @(posedge i_clk);
        mode_we  <= 1'b0;
    endtask

    task automatic build_string(input hpc_pkg::t_mode m);
        int         len;
        int         kind;
        logic [7:0] b;
        str_q.delete();
        case (m)
            hpc_pkg::MODE_HEX_ENC, hpc_pkg::MODE_URL_ENC: begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    kind = $urandom_range(0, 2);
                    if (kind == 0) begin
                        b = 8'($urandom);
                    end else if (kind == 1) begin
                        b = mixed_chars[$urandom_range(0, mixed_chars.len() - 1)];
                    end else begin
                        b = 8'($urandom_range(128, 255));
                    end
                    str_q.push_back(b);
                end
            end
            hpc_pkg::MODE_HEX_DEC: begin
                len = 2 * $urandom_range(1, 5);
                repeat (len) str_q.push_back(rand_hex_digit());
                if ($urandom_range(0, 99) < 15) begin
                    if ($urandom_range(0, 1) == 1) begin
                        str_q.delete(str_q.size() - 1);
                    end else begin
                        str_q[$urandom_range(0, str_q.size() - 1)] = rand_non_hex();
                    end
                end
            end
            hpc_pkg::MODE_URL_DEC: begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 60) begin
                        b = 8'($urandom);
                        if (b == hpc_pkg::CH_PERCENT) b = "+";
                        str_q.push_back(b);
                    end else begin
                        str_q.push_back(hpc_pkg::CH_PERCENT);
                        str_q.push_back(rand_hex_digit());
                        str_q.push_back(rand_hex_digit());
                    end
                end
                if ($urandom_range(0, 99) < 15) begin
                    kind = $urandom_range(0, 2);
                    str_q.push_back(hpc_pkg::CH_PERCENT);
                    if (kind == 1) begin
                        str_q.push_back(rand_hex_digit());
                    end else if (kind == 2) begin
                        str_q.push_back(rand_non_hex());
                        str_q.push_back(rand_hex_digit());
                    end
                end
            end
            default: begin
                str_q.push_back(8'h00);
            end
        endcase
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings
        set_mode(hpc_pkg::MODE_HEX_ENC);
        str_q = '{8'h00, 8'hFF};
        send_string();
        drain();
        set_mode(hpc_pkg::MODE_HEX_DEC);
        str_q = '{"F", "a", "7"};
        send_string();
        str_q = '{"g", "1"};
        send_string();
        drain();
        set_mode(hpc_pkg::MODE_URL_ENC);
        str_q = '{"~", 8'h20, 8'h00, 8'hFF, "."};
        send_string();
        drain();
        set_mode(hpc_pkg::MODE_URL_DEC);
        str_q = '{"%", "4", "a", "x", "%"};
        send_string();
        str_q = '{"%", "z", "Q"};
        send_string();
        drain();
        // mode change in the middle of a string keeps the digit state
        set_mode(hpc_pkg::MODE_HEX_DEC);
        put_byte("4", 1'b0);
        drain();
        set_mode(hpc_pkg::MODE_URL_DEC);
        str_q = '{"1", "2"};
        send_string();
        drain();
        set_mode(hpc_pkg::MODE_HEX_DEC);
        put_byte("x", 1'b0);
        drain();
        set_mode(hpc_pkg::MODE_HEX_ENC);
        put_byte(8'h41, 1'b1);
        drain();

        // random phases, one mode each
        while (item_cnt < ITEM_TARGET) begin
            if (phase_idx < 4) begin
                cur_mode = hpc_pkg::t_mode'(phase_idx);
            end else begin
                cur_mode = hpc_pkg::t_mode'($urandom_range(0, 3));
            end
            set_mode(cur_mode);
            phase_len   = $urandom_range(25, 60);
            phase_start = item_cnt;
            while (item_cnt - phase_start < phase_len && item_cnt < ITEM_TARGET) begin
                build_string(cur_mode);
                send_string();
            end
            drain();
            phase_idx++;
        end

        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("[hex_and_percent_text_codec] OK");
        end else begin
            $display("[hex_and_percent_text_codec] ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[hex_and_percent_text_codec] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hpc_pkg.sv
rtl/hpc_front.sv
rtl/hpc_queue.sv
rtl/hpc_back.sv
rtl/hex_and_percent_text_codec.sv
rtl/hpc_checker.sv
dv/codec_checker.sv
dv/tb_top.sv
